// ===== src/policy_ordered_ready_queue_top_assert.svh =====
// assertion macros for the policy ordered ready queue checker
// no dependencies; expects i_clk and i_rst_n in the including scope
`ifndef POLICY_ORDERED_READY_QUEUE_TOP_ASSERT_SVH
`define POLICY_ORDERED_READY_QUEUE_TOP_ASSERT_SVH

// checked only out of reset
`define PORQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PORQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/porq_pkg.sv =====
// shared types and constants of the policy ordered ready queue
// no dependencies
`timescale 1ns / 1ps

package porq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int HANDLE_W    = 32;
    localparam int COST_W      = 8;
    localparam int PRIO_W      = 8;

    // opcodes
    localparam logic [1:0] OP_SPAWN    = 2'd0;
    localparam logic [1:0] OP_TAKE     = 2'd1;
    localparam logic [1:0] OP_WITHDRAW = 2'd2;

    // ordering policies
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOID  = 2'd3;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
        logic [COST_W-1:0]   cost;
        logic [PRIO_W-1:0]   prio;
    } t_entry;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_stat;

endpackage

// ===== src/porq_ctrl.sv =====
// controller of the ready queue: operation sequencing and output valid
// depends on porq_pkg
`timescale 1ns / 1ps

module porq_ctrl import porq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_COMMIT: begin
                // wait for room in the output register
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/porq_dp.sv =====
// datapath of the ready queue: entry registers, scan, insert and remove
// depends on porq_pkg
`timescale 1ns / 1ps

module porq_dp import porq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    input  logic [1:0]          i_opcode,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [COST_W-1:0]   i_cost,
    input  logic [PRIO_W-1:0]   i_prio,
    input  logic [ID_W-1:0]     i_wanted_id,
    output logic [1:0]          o_status,
    output logic [ID_W-1:0]     o_task_id,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic [CNT_W-1:0]    o_ready_count
);

    logic [1:0]          r_policy;
    logic [CNT_W-1:0]    r_count;
    logic [ID_W-1:0]     r_next_id;
    logic [CNT_W-1:0]    r_idx;

    logic [1:0]          r_op;
    logic [HANDLE_W-1:0] r_handle;
    logic [COST_W-1:0]   r_cost;
    logic [PRIO_W-1:0]   r_prio;
    logic [ID_W-1:0]     r_want;

    t_entry              r_entries [QUEUE_DEPTH];
    t_entry              w_prev    [QUEUE_DEPTH];
    t_entry              w_next    [QUEUE_DEPTH];

    logic [1:0]          r_status;
    logic [ID_W-1:0]     r_tid;
    logic [HANDLE_W-1:0] r_hnd;
    logic [CNT_W-1:0]    r_cnt;

    t_entry              cur;
    t_entry              new_e;
    logic                in_range;
    logic                hit;
    logic                full;
    logic                do_ins;
    logic                do_rem;
    logic [ID_W-1:0]     n_id;
    logic [1:0]          n_status;
    logic [ID_W-1:0]     n_tid;
    logic [HANDLE_W-1:0] n_hnd;
    logic [CNT_W-1:0]    n_count;

    // neighbor taps for the shift network
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_tap
        if (gi == 0) begin : g_first
            assign w_prev[gi] = '0;
        end else begin : g_prev
            assign w_prev[gi] = r_entries[gi-1];
        end
        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign w_next[gi] = '0;
        end else begin : g_next
            assign w_next[gi] = r_entries[gi+1];
        end
    end

    // one entry examined per scan step
    assign cur      = r_entries[r_idx[IDX_W-1:0]];
    assign in_range = (r_idx < r_count);
    assign full     = (r_count == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        case (r_op)
            OP_SPAWN: begin
                hit = in_range &&
                      (((r_policy == POL_SJF) && (cur.cost > r_cost)) ||
                       ((r_policy == POL_PRIO) && (cur.prio < r_prio)));
            end
            OP_WITHDRAW: begin
                hit = in_range && (cur.id == r_want);
            end
            default: begin
                hit = 1'b1;
            end
        endcase
    end

    assign o_stat.scan_done = hit || !in_range;

    // next id skips zero on wrap
    always_comb begin
        n_id = r_next_id + 1'b1;
        if (n_id == '0) begin
            n_id = ID_W'(1);
        end
    end

    assign new_e.handle = r_handle;
    assign new_e.id     = n_id;
    assign new_e.cost   = r_cost;
    assign new_e.prio   = r_prio;

    assign do_ins = i_cmd.commit && (r_op == OP_SPAWN) && !full;
    assign do_rem = i_cmd.commit &&
                    (((r_op == OP_TAKE) && (r_count != '0)) ||
                     ((r_op == OP_WITHDRAW) && hit));

    always_comb begin
        n_status = ST_OK;
        n_tid    = '0;
        n_hnd    = '0;
        n_count  = r_count;
        case (r_op)
            OP_SPAWN: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_tid   = n_id;
                    n_count = r_count + 1'b1;
                end
            end
            OP_TAKE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_tid   = cur.id;
                    n_hnd   = cur.handle;
                    n_count = r_count - 1'b1;
                end
            end
            OP_WITHDRAW: begin
                n_tid = r_want;
                if (hit) begin
                    n_hnd   = cur.handle;
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ST_NOID;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= POL_FCFS;
            r_count   <= '0;
            r_next_id <= '0;
            r_idx     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_policy <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.commit) begin
                r_count <= n_count;
            end
            if (do_ins) begin
                r_next_id <= n_id;
            end
        end
    end

    // captured operation and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_handle <= i_handle;
            r_cost   <= i_cost;
            r_prio   <= i_prio;
            r_want   <= i_wanted_id;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_tid    <= n_tid;
            r_hnd    <= n_hnd;
            r_cnt    <= n_count;
        end
    end

    // insert at scan position shifts the tail up, remove shifts it down
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (do_ins) begin
                if (CNT_W'(i) == r_idx) begin
                    r_entries[i] <= new_e;
                end else if ((CNT_W'(i) > r_idx) && (CNT_W'(i) <= r_count)) begin
                    r_entries[i] <= w_prev[i];
                end
            end else if (do_rem) begin
                if ((CNT_W'(i) >= r_idx) && ((CNT_W'(i) + 1'b1) < r_count)) begin
                    r_entries[i] <= w_next[i];
                end
            end
        end
    end

    assign o_status      = r_status;
    assign o_task_id     = r_tid;
    assign o_out_handle  = r_hnd;
    assign o_ready_count = r_cnt;

endmodule

// ===== src/policy_ordered_ready_queue_top.sv =====
// policy ordered ready queue, top level: stream ports, controller and datapath
// an item is loaded, a scan examines 0 to 16 entries one at a time, and the result is committed
// a new item is taken only in idle, once the previous item has been committed to the output
// a waiting result sits in the output register while the next item is taken
// reset (i_rst_n low, synchronous) empties the queue, zeroes the id, policy fcfs
`timescale 1ns / 1ps

module policy_ordered_ready_queue_top import porq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: policy_mode
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // task_handle, task_cost, task_priority, wanted_id
    input  logic [1:0]  s_axis_tuser,   // opcode
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // task_id, out_handle, ready_count, zero fill
    output logic [1:0]  m_axis_tuser    // status
);

    t_dp_cmd             cmd;
    t_dp_stat            stat;
    logic [ID_W-1:0]     task_id;
    logic [HANDLE_W-1:0] out_handle;
    logic [CNT_W-1:0]    ready_count;

    // sequencing: idle, scan one entry per cycle, commit into output register
    porq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // entries, id counter, policy register and result register
    porq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_opcode      (s_axis_tuser),
        .i_handle      (s_axis_tdata[31:0]),
        .i_cost        (s_axis_tdata[39:32]),
        .i_prio        (s_axis_tdata[47:40]),
        .i_wanted_id   (s_axis_tdata[63:48]),
        .o_status      (m_axis_tuser),
        .o_task_id     (task_id),
        .o_out_handle  (out_handle),
        .o_ready_count (ready_count)
    );

    // pack result fields, lowest first
    assign m_axis_tdata = {3'b000, ready_count, out_handle, task_id};

endmodule

// ===== src/porq_checker.sv =====
// port-level checker for the policy ordered ready queue, bound to the top level
// depends on porq_pkg and policy_ordered_ready_queue_top_assert.svh
`timescale 1ns / 1ps
`include "policy_ordered_ready_queue_top_assert.svh"

module porq_checker import porq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    `PORQ_ASSERT(a_out_hold,
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result changed while stalled")

    // one item at a time: ready drops after an accept
    `PORQ_ASSERT(a_busy_after_accept,
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
        "item accepted while busy")

    // count never exceeds the queue depth
    `PORQ_ASSERT(a_count_bound,
        m_axis_tvalid |-> m_axis_tdata[52:48] <= 5'd16,
        "ready count above depth")

    // dropped spawn or empty take carries no task
    `PORQ_ASSERT(a_fail_zero,
        m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_EMPTY) |->
            m_axis_tdata[47:0] == 48'd0,
        "failed op returned a task")

    // reset clears the output side
    `PORQ_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind policy_ordered_ready_queue_top porq_checker u_porq_checker (.*);
